>>> hdl/srfsr_pkg.sv
package srfsr_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int MAX_BLOCK  = 64;
    localparam int CNT_W      = 7;
    localparam int SAMPLE_W   = 16;
    localparam int PAIR_W     = 2 * SAMPLE_W;
    localparam int DIV_STEPS  = IDX_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int REM_W      = CNT_W + 2;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SAMPLES = 1'b1;

    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_PLAIN   = 2'd1,
        REQ_STRETCH = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_WRITTEN = 2'd0,
        ST_DROPPED = 2'd1,
        ST_PAIR    = 2'd2,
        ST_REFUSED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        DEC_NONE,
        DEC_WRITE,
        DEC_DROP,
        DEC_REFUSE,
        DEC_PLAIN,
        DEC_STRETCH
    } dec_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV,
        S_READ,
        S_PAIR,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic    latch_req;
        logic    write_mem;
        logic    init_plain;
        logic    init_stretch;
        logic    div_step;
        logic    read_mem;
        logic    load_pair;
        logic    load_single;
        status_t single_status;
    } ctrl_cmd_t;

    typedef struct packed {
        dec_t decision;
        logic div_done;
        logic pair_last;
        logic out_free;
    } dp_stat_t;

endpackage

>>> hdl/srfsr_if.sv
interface srfsr_req_if;
    import srfsr_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 req_type;
    logic signed [SAMPLE_W-1:0] in_right;
    logic signed [SAMPLE_W-1:0] in_left;
    logic [CNT_W-1:0]           request_count;
    modport source (output valid, req_type, in_right, in_left, request_count, input ready);
    modport sink (input valid, req_type, in_right, in_left, request_count, output ready);
endinterface

interface srfsr_rsp_if;
    import srfsr_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_right;
    logic signed [SAMPLE_W-1:0] out_left;
    logic [1:0]                 status;
    logic                       last;
    modport source (output valid, out_right, out_left, status, last, input ready);
    modport sink (input valid, out_right, out_left, status, last, output ready);
endinterface

interface srfsr_cfg_if;
    import srfsr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CNT_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/srfsr_ctrl.sv
module srfsr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  srfsr_pkg::dp_stat_t  stat,
    output srfsr_pkg::ctrl_cmd_t cmd
);
    import srfsr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (stat.decision)
                    DEC_WRITE, DEC_DROP, DEC_REFUSE: state_next = S_RESULT;
                    DEC_PLAIN:                       state_next = S_READ;
                    DEC_STRETCH:                     state_next = S_DIV;
                    default:                         state_next = S_IDLE;
                endcase
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_PAIR;
            end
            S_PAIR:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.pair_last ? S_IDLE : S_READ;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready     = 1'b1;
                cmd.latch_req = req_valid;
            end
            S_DECIDE:
            begin
                cmd.write_mem    = (stat.decision == DEC_WRITE);
                cmd.init_plain   = (stat.decision == DEC_PLAIN);
                cmd.init_stretch = (stat.decision == DEC_STRETCH);
            end
            S_DIV:
            begin
                cmd.div_step = !stat.div_done;
            end
            S_READ:
            begin
                cmd.read_mem = 1'b1;
            end
            S_PAIR:
            begin
                cmd.load_pair = stat.out_free;
            end
            S_RESULT:
            begin
                cmd.load_single = stat.out_free;
                case (stat.decision)
                    DEC_WRITE: cmd.single_status = ST_WRITTEN;
                    DEC_DROP:  cmd.single_status = ST_DROPPED;
                    default:   cmd.single_status = ST_REFUSED;
                endcase
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> hdl/srfsr_dp.sv
module srfsr_dp (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  srfsr_pkg::ctrl_cmd_t                     cmd,
    output srfsr_pkg::dp_stat_t                      stat,
    input  logic [1:0]                               req_type,
    input  logic signed [srfsr_pkg::SAMPLE_W-1:0]    in_right,
    input  logic signed [srfsr_pkg::SAMPLE_W-1:0]    in_left,
    input  logic [srfsr_pkg::CNT_W-1:0]              request_count,
    input  logic                                     cfg_we,
    input  logic [srfsr_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [srfsr_pkg::CNT_W-1:0]              cfg_data,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [srfsr_pkg::SAMPLE_W-1:0]    out_right,
    output logic signed [srfsr_pkg::SAMPLE_W-1:0]    out_left,
    output logic [1:0]                               out_status,
    output logic                                     out_last
);
    import srfsr_pkg::*;

    logic [PAIR_W-1:0] mem [RING_DEPTH];
    logic [PAIR_W-1:0] rdata_reg;
    logic              rd_zero_reg;

    logic             limit_reg;
    logic [CNT_W-1:0] block_reg;
    logic [IDX_W-1:0] wr_idx_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             zero_written_reg;

    logic [1:0]         type_reg;
    logic [PAIR_W-1:0]  pair_reg;
    logic [CNT_W-1:0]   n_reg;
    logic               req_one_reg;
    logic [IDX_W-1:0]   used_reg;
    logic [IDX_W-1:0]   adv_reg;

    logic [IDX_W-1:0]     div_quo_reg;
    logic [CNT_W:0]       div_rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [IDX_W-1:0]     src_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     k_reg;

    logic                 out_valid_reg;
    logic [SAMPLE_W-1:0]  out_right_reg;
    logic [SAMPLE_W-1:0]  out_left_reg;
    logic [1:0]           out_status_reg;
    logic                 out_last_reg;

    logic [CNT_W-1:0] blk_eff;
    logic [CNT_W-1:0] n_next;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W:0]   div_shift;
    logic             div_ge;
    logic [REM_W-1:0] rem_sum;
    logic [REM_W-1:0] two_n;
    logic             rem_wrap;
    dec_t             decision;

    always_comb
    begin
        if (block_reg == '0)
        begin
            blk_eff = CNT_W'(1);
        end
        else if (block_reg > CNT_W'(MAX_BLOCK))
        begin
            blk_eff = CNT_W'(MAX_BLOCK);
        end
        else
        begin
            blk_eff = block_reg;
        end
        if (request_count == '0)
        begin
            n_next = blk_eff;
        end
        else if (request_count > CNT_W'(MAX_BLOCK))
        begin
            n_next = CNT_W'(MAX_BLOCK);
        end
        else
        begin
            n_next = request_count;
        end
    end

    always_comb
    begin
        case (type_reg)
            REQ_WRITE:
            begin
                decision = (used_reg == IDX_W'(RING_DEPTH - 1)) ? DEC_DROP : DEC_WRITE;
            end
            REQ_PLAIN:
            begin
                decision = (used_reg < IDX_W'(n_reg)) ? DEC_REFUSE : DEC_PLAIN;
            end
            REQ_STRETCH:
            begin
                if (req_one_reg || used_reg == '0)
                begin
                    decision = DEC_REFUSE;
                end
                else if (limit_reg && used_reg >= IDX_W'(n_reg))
                begin
                    decision = DEC_PLAIN;
                end
                else
                begin
                    decision = DEC_STRETCH;
                end
            end
            default:
            begin
                decision = DEC_NONE;
            end
        endcase
    end

    assign slot      = wr_idx_reg + IDX_W'(1);
    assign rd_addr   = rd_idx_reg + src_reg;
    assign div_shift = {div_rem_reg[CNT_W-1:0], div_quo_reg[IDX_W-1]};
    assign div_ge    = (div_shift >= {1'b0, n_reg});
    assign two_n     = REM_W'({n_reg, 1'b0});
    assign rem_sum   = rem_reg + REM_W'({div_rem_reg, 1'b0});
    assign rem_wrap  = (rem_sum >= two_n);

    assign stat.decision  = decision;
    assign stat.div_done  = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS));
    assign stat.pair_last = (k_reg == n_reg - CNT_W'(1));
    assign stat.out_free  = !out_valid_reg || out_ready;

    // sample store, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.write_mem)
        begin
            mem[slot] <= pair_reg;
        end
        if (cmd.read_mem)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // request fields and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            type_reg    <= req_type;
            pair_reg    <= {in_right, in_left};
            n_reg       <= n_next;
            req_one_reg <= (request_count == CNT_W'(1));
            used_reg    <= wr_idx_reg - rd_idx_reg;
        end
        if (cmd.init_plain)
        begin
            adv_reg <= IDX_W'(n_reg);
        end
        if (cmd.init_stretch)
        begin
            adv_reg <= used_reg;
        end
        if (cmd.load_pair)
        begin
            out_right_reg  <= rd_zero_reg ? '0 : rdata_reg[PAIR_W-1:SAMPLE_W];
            out_left_reg   <= rd_zero_reg ? '0 : rdata_reg[SAMPLE_W-1:0];
            out_status_reg <= ST_PAIR;
            out_last_reg   <= stat.pair_last;
        end
        if (cmd.load_single)
        begin
            out_right_reg  <= '0;
            out_left_reg   <= '0;
            out_status_reg <= cmd.single_status;
            out_last_reg   <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg        <= 1'b1;
            block_reg        <= CNT_W'(MAX_BLOCK);
            wr_idx_reg       <= '0;
            rd_idx_reg       <= '0;
            zero_written_reg <= 1'b0;
            rd_zero_reg      <= 1'b0;
            div_quo_reg      <= '0;
            div_rem_reg      <= '0;
            div_cnt_reg      <= '0;
            src_reg          <= '0;
            rem_reg          <= '0;
            k_reg            <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LIMIT_MODE:    limit_reg <= cfg_data[0];
                    CFG_BLOCK_SAMPLES: block_reg <= cfg_data;
                    default:           limit_reg <= limit_reg;
                endcase
            end
            if (cmd.write_mem)
            begin
                wr_idx_reg <= slot;
                if (slot == '0)
                begin
                    zero_written_reg <= 1'b1;
                end
            end
            if (cmd.read_mem)
            begin
                rd_zero_reg <= (rd_addr == '0) && !zero_written_reg;
            end
            // plain read: unit step, no remainder
            if (cmd.init_plain)
            begin
                div_quo_reg <= IDX_W'(1);
                div_rem_reg <= '0;
                div_cnt_reg <= DIV_CNT_W'(DIV_STEPS);
                src_reg     <= '0;
                rem_reg     <= REM_W'(n_reg - CNT_W'(1));
                k_reg       <= '0;
            end
            // stretch read: used / n gives the index step
            if (cmd.init_stretch)
            begin
                div_quo_reg <= used_reg;
                div_rem_reg <= '0;
                div_cnt_reg <= '0;
                src_reg     <= '0;
                rem_reg     <= REM_W'(n_reg - CNT_W'(1));
                k_reg       <= '0;
            end
            if (cmd.div_step)
            begin
                div_quo_reg <= {div_quo_reg[IDX_W-2:0], div_ge};
                div_rem_reg <= div_ge ? (div_shift - {1'b0, n_reg}) : div_shift;
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            if (cmd.load_pair)
            begin
                if (stat.pair_last)
                begin
                    rd_idx_reg <= rd_idx_reg + adv_reg;
                end
                else
                begin
                    k_reg <= k_reg + CNT_W'(1);
                    if (rem_wrap)
                    begin
                        rem_reg <= rem_sum - two_n;
                        src_reg <= src_reg + div_quo_reg + IDX_W'(1);
                    end
                    else
                    begin
                        rem_reg <= rem_sum;
                        src_reg <= src_reg + div_quo_reg;
                    end
                end
            end
            if (cmd.load_pair || cmd.load_single)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_right  = out_right_reg;
    assign out_left   = out_left_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

>>> hdl/stereo_ring_fifo_stretch_read_core.sv
// channel   dir  payload                                      transaction
// req_ch    in   req_type, in_right, in_left, request_count   valid && ready
// rsp_ch    out  out_right, out_left, status, last            valid && ready
// cfg_ch    in   index, data                                  valid && ready
//
// one request at a time; a write or a refused read passes from accept through the decide and result states
// a plain read does one store read and one output load per pair
// a stretch read, unless limit mode serves it as a plain read, first runs the bit-serial used / N divider
// the result register lets the next request be accepted while the last result waits
// async reset clears indices and control; only store entry zero reads as zero until written
module stereo_ring_fifo_stretch_read_core (
    input logic         clk,
    input logic         rst_n,
    srfsr_req_if.sink   req_ch,
    srfsr_rsp_if.source rsp_ch,
    srfsr_cfg_if.sink   cfg_ch
);
    import srfsr_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;
    logic      req_ready;

    assign req_ch.ready = req_ready;
    assign cfg_ch.ready = 1'b1;

    srfsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_ch.valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    srfsr_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (req_ch.req_type),
        .in_right      (req_ch.in_right),
        .in_left       (req_ch.in_left),
        .request_count (req_ch.request_count),
        .cfg_we        (cfg_ch.valid),
        .cfg_index     (cfg_ch.index),
        .cfg_data      (cfg_ch.data),
        .out_valid     (rsp_ch.valid),
        .out_ready     (rsp_ch.ready),
        .out_right     (rsp_ch.out_right),
        .out_left      (rsp_ch.out_left),
        .out_status    (rsp_ch.status),
        .out_last      (rsp_ch.last)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
        else $error("request accepted while previous still in progress");

    a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_ch.valid && rsp_ch.status != ST_PAIR) |-> rsp_ch.last)
        else $error("single result without last");

    a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_ch.valid && rsp_ch.status != ST_PAIR)
            |-> (rsp_ch.out_right == '0 && rsp_ch.out_left == '0))
        else $error("non-pair result carries samples");

endmodule

>>> bench/stereo_ring_fifo_stretch_read_core_test.sv
`timescale 1ns / 1ps

module stereo_ring_fifo_stretch_read_core_test;
    import srfsr_pkg::*;

    typedef struct packed {
        logic [1:0]          kind;
        logic [SAMPLE_W-1:0] right;
        logic [SAMPLE_W-1:0] left;
        logic [CNT_W-1:0]    count;
    } request_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] right;
        logic [SAMPLE_W-1:0] left;
        logic [1:0]          status;
        logic                last;
    } pair_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    srfsr_req_if req_ch ();
    srfsr_rsp_if rsp_ch ();
    srfsr_cfg_if cfg_ch ();

    stereo_ring_fifo_stretch_read_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .req_ch (req_ch.sink),
        .rsp_ch (rsp_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    logic [SAMPLE_W-1:0] ring_right [RING_DEPTH];
    logic [SAMPLE_W-1:0] ring_left [RING_DEPTH];
    logic                ring_valid [RING_DEPTH];
    int unsigned         wr_idx;
    int unsigned         rd_idx;
    logic                mdl_limit;
    int unsigned         mdl_block;

    request_t     pending_reqs [$];
    pair_result_t expected_pairs [$];
    int           errors;
    int           mismatches;
    int           cycles;
    logic         quiet;
    logic         hold_off;
    int           send_gap;
    int           recv_gap;

    function automatic int unsigned stored_pairs();
        return (wr_idx + RING_DEPTH - rd_idx) % RING_DEPTH;
    endfunction

    function automatic int unsigned eff_count(int unsigned req);
        int unsigned b;
        b = (mdl_block == 0) ? 1 : ((mdl_block > MAX_BLOCK) ? MAX_BLOCK : mdl_block);
        if (req == 0)
            return b;
        return (req > MAX_BLOCK) ? MAX_BLOCK : req;
    endfunction

    task automatic push_pair(int unsigned idx, int unsigned k, int unsigned n);
        pair_result_t p;
        p.right  = ring_right[idx];
        p.left   = ring_left[idx];
        p.status = ST_PAIR;
        p.last   = (k + 1 == n);
        expected_pairs.push_back(p);
    endtask

    task automatic push_single(status_t st);
        pair_result_t p;
        p = '0;
        p.status = st;
        p.last   = 1'b1;
        expected_pairs.push_back(p);
    endtask

    task automatic predict_request(request_t r);
        int unsigned used;
        int unsigned n;
        int unsigned src;
        used = stored_pairs();
        n = eff_count(r.count);
        if (r.kind == REQ_WRITE)
        begin
            if (used == RING_DEPTH - 1)
                push_single(ST_DROPPED);
            else
            begin
                wr_idx = (wr_idx + 1) % RING_DEPTH;
                ring_right[wr_idx] = r.right;
                ring_left[wr_idx]  = r.left;
                ring_valid[wr_idx] = 1'b1;
                push_single(ST_WRITTEN);
            end
        end
        else if (r.kind == REQ_PLAIN || r.kind == REQ_STRETCH)
        begin
            if (r.kind == REQ_STRETCH && (r.count == 1 || used == 0))
                push_single(ST_REFUSED);
            else if (used >= n && (r.kind == REQ_PLAIN || mdl_limit))
            begin
                for (int unsigned k = 0; k < n; k++)
                    push_pair((rd_idx + k) % RING_DEPTH, k, n);
                rd_idx = (rd_idx + n) % RING_DEPTH;
            end
            else if (r.kind == REQ_PLAIN)
                push_single(ST_REFUSED);
            else
            begin
                for (int unsigned k = 0; k < n; k++)
                begin
                    src = (n - 1 + 2 * used * k) / (2 * n);
                    push_pair((rd_idx + src) % RING_DEPTH, k, n);
                end
                rd_idx = (rd_idx + used) % RING_DEPTH;
            end
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.req_type <= '0;
            req_ch.in_right <= '0;
            req_ch.in_left <= '0;
            req_ch.request_count <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_request(pending_reqs.pop_front());
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0 && !hold_off)
                begin
                    request_t nx;
                    nx = pending_reqs[0];
                    req_ch.valid <= 1'b1;
                    req_ch.req_type <= nx.kind;
                    req_ch.in_right <= nx.right;
                    req_ch.in_left <= nx.left;
                    req_ch.request_count <= nx.count;
                    if (!quiet && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 10);
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                pair_result_t got;
                pair_result_t exp;
                got.right = rsp_ch.out_right;
                got.left = rsp_ch.out_left;
                got.status = rsp_ch.status;
                got.last = rsp_ch.last;
                if (expected_pairs.size() == 0)
                begin
                    errors = errors + 1;
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected transaction: %h", got);
                end
                else
                begin
                    exp = expected_pairs.pop_front();
                    if (got !== exp)
                    begin
                        errors = errors + 1;
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display({"mismatch: expected r=%h l=%h st=%0d last=%b, ",
                                      "got r=%h l=%h st=%0d last=%b"},
                                exp.right, exp.left, exp.status, exp.last,
                                got.right, got.left, got.status, got.last);
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    recv_gap <= $urandom_range(1, 10);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic add_req(logic [1:0] kind, logic [15:0] r, logic [15:0] l,
                           logic [CNT_W-1:0] cnt);
        request_t q;
        q.kind = kind;
        q.right = r;
        q.left = l;
        q.count = cnt;
        pending_reqs.push_back(q);
    endtask

    task automatic add_write();
        add_req(REQ_WRITE, $urandom, $urandom, $urandom);
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_pairs.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_LIMIT_MODE)
            mdl_limit = val[0];
        else
            mdl_block = val;
        @(posedge clk);
    endtask

    // reads never reach slots that were not written, except slot zero
    function automatic logic read_safe(logic [1:0] kind, int unsigned cnt);
        int unsigned used;
        int unsigned n;
        used = stored_pairs();
        n = eff_count(cnt);
        if (kind == REQ_PLAIN)
            return (used < n) || ring_valid[(rd_idx + n - 1) % RING_DEPTH];
        return 1'b1;
    endfunction

    initial
    begin
        int unsigned c;
        errors = 0;
        mismatches = 0;
        cycles = 0;
        quiet = 1'b0;
        hold_off = 1'b0;
        wr_idx = 0;
        rd_idx = 0;
        mdl_limit = 1'b1;
        mdl_block = 64;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            ring_right[i] = '0;
            ring_left[i] = '0;
            ring_valid[i] = (i == 0);
        end
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty reads, extremes, unused type
        add_req(REQ_STRETCH, 0, 0, 0);
        add_req(REQ_PLAIN, 0, 0, 1);
        add_req(2'd3, 16'hffff, 16'hffff, 7'h7f);
        add_req(REQ_WRITE, 16'h8000, 16'h7fff, 0);
        add_req(REQ_WRITE, 16'h7fff, 16'h8000, 7'h7f);
        add_req(REQ_WRITE, 16'hffff, 16'h0000, 0);
        add_req(REQ_STRETCH, 0, 0, 1);
        add_req(REQ_PLAIN, 0, 0, 2);
        add_req(REQ_STRETCH, 0, 0, 7'h7f);
        add_req(REQ_WRITE, 16'h0000, 16'hffff, 0);
        add_req(REQ_PLAIN, 0, 0, 1);
        drain();
        write_reg(CFG_BLOCK_SAMPLES, 0);
        write_reg(CFG_LIMIT_MODE, 0);
        add_write();
        add_write();
        add_req(REQ_PLAIN, 0, 0, 0);
        add_req(REQ_STRETCH, 0, 0, 0);
        add_req(REQ_STRETCH, 0, 0, 0);
        drain();
        write_reg(CFG_BLOCK_SAMPLES, 7'h7f);
        // queue a burst of writes before the sender starts
        hold_off = 1'b1;
        for (int i = 0; i < 20; i++)
            add_write();
        hold_off = 1'b0;
        drain();
        write_reg(CFG_LIMIT_MODE, 1);
        add_req(REQ_PLAIN, 0, 0, 0);
        add_req(REQ_STRETCH, 0, 0, 64);
        drain();

        // random phases with various settings
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(CFG_LIMIT_MODE, $urandom_range(0, 1));
            write_reg(CFG_BLOCK_SAMPLES, (ph == 3) ? 1 : $urandom_range(1, 16));
            if (ph == 3)
                quiet = 1'b1;
            for (int i = 0; i < 18; i++)
            begin
                c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
                if ($urandom_range(0, 9) < 6)
                    add_write();
                else
                begin
                    while (pending_reqs.size() != 0 || req_ch.valid)
                        @(posedge clk);
                    if ($urandom_range(0, 1) && read_safe(REQ_PLAIN, c))
                        add_req(REQ_PLAIN, $urandom, $urandom, c);
                    else
                        add_req(REQ_STRETCH, $urandom, $urandom, c);
                end
            end
            drain();
        end

        if (errors == 0 && expected_pairs.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
